// ----- sv/escaped_frame_deframer_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef ESCAPED_FRAME_DEFRAMER_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define EFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- sv/efd_pkg.sv -----
// Types, constants and the per-byte framing function of the deframer.
package efd_pkg;

  localparam int unsigned FRAME_OVERHEAD_DEFAULT = 3;

  localparam logic [7:0] ESC_BYTE  = 8'h56;
  localparam logic [7:0] ESC_SELF  = 8'h57;
  localparam logic [7:0] LEAD_BYTE = 8'h55;
  localparam logic [7:0] LEN_MAX   = 8'd84;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0] win_old;
    logic [7:0] win_new;
    logic [1:0] fill;
    logic       in_frame;
    logic [6:0] remaining;
  } hunt_state_t;

  typedef struct packed {
    logic [1:0]      count;
    beat_t [2:0]     beats;
  } beat_group_t;

  typedef struct packed {
    hunt_state_t st;
    beat_group_t grp;
  } step_t;

  function automatic step_t frame_step(hunt_state_t st, logic [7:0] b, logic [6:0] extra);
    step_t      r;
    logic [6:0] rem;
    r = '0;
    r.st = st;
    rem = '0;
    if (st.in_frame) begin
      rem = (st.remaining == 7'd0) ? 7'd0 : st.remaining - 7'd1;
      r.st.remaining = rem;
      r.grp.count = 2'd1;
      r.grp.beats[0] = '{data: b, first: 1'b0, last: (rem == 7'd0)};
      if (rem == 7'd0) begin
        r.st.in_frame = 1'b0;
        r.st.fill = 2'd0;
        r.st.win_old = 8'd0;
        r.st.win_new = 8'd0;
      end
    end else if (st.fill >= 2'd2 && st.win_old == LEAD_BYTE && st.win_new == 8'd0 &&
                 b >= 8'd1 && b <= LEN_MAX) begin
      rem = b[6:0] + extra;
      r.grp.count = 2'd3;
      r.grp.beats[0] = '{data: LEAD_BYTE, first: 1'b1, last: 1'b0};
      r.grp.beats[1] = '{data: 8'd0, first: 1'b0, last: 1'b0};
      r.grp.beats[2] = '{data: b, first: 1'b0, last: (rem == 7'd0)};
      r.st.fill = 2'd0;
      r.st.win_old = 8'd0;
      r.st.win_new = 8'd0;
      r.st.in_frame = (rem != 7'd0);
      r.st.remaining = rem;
    end else begin
      r.st.win_old = st.win_new;
      r.st.win_new = b;
      if (st.fill < 2'd2) begin
        r.st.fill = st.fill + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/efd_raw_if.sv -----
// Handshake channel carrying one escaped link byte per beat.
interface efd_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

// ----- sv/efd_frame_if.sv -----
// Handshake channel carrying one unescaped frame byte with its markers per beat.
interface efd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       first_of_frame;
  logic       last_of_frame;

  modport source (output valid, output frame_byte, output first_of_frame,
                  output last_of_frame, input ready);
  modport sink (input valid, input frame_byte, input first_of_frame,
                input last_of_frame, output ready);
endinterface

// ----- sv/efd_in_stage.sv -----
// Input register holding one escaped byte until the engine takes it.
module efd_in_stage (
  input  logic       clk,
  input  logic       rst,
  efd_raw_if.sink    raw,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_byte
);
  import efd_pkg::*;

  assign raw.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (raw.valid && raw.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      item_byte <= raw.raw_byte;
    end
  end
endmodule

// ----- sv/efd_engine.sv -----
// Unescape and header hunt: escape and framing state plus the beat group of one byte.
module efd_engine #(
  parameter int unsigned FRAME_OVERHEAD = efd_pkg::FRAME_OVERHEAD_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          item_byte,
  output efd_pkg::beat_group_t grp
);
  import efd_pkg::*;

  localparam logic [6:0] EXTRA = 7'(FRAME_OVERHEAD - 3);

  logic        escape_pending;
  logic        escape_pending_next;
  hunt_state_t st;
  hunt_state_t st_next;
  step_t       s1;
  step_t       s2;
  logic [7:0]  first_byte;
  logic        use1;
  logic        use2;

  always_comb begin
    first_byte = item_byte;
    if (escape_pending) begin
      first_byte = (item_byte == ESC_BYTE) ? LEAD_BYTE : ESC_BYTE;
    end
    use1 = escape_pending || (item_byte != ESC_BYTE);
    use2 = escape_pending && (item_byte != ESC_BYTE) && (item_byte != ESC_SELF);
    escape_pending_next = !escape_pending && (item_byte == ESC_BYTE);
    s1 = frame_step(st, first_byte, EXTRA);
    s2 = frame_step(s1.st, item_byte, EXTRA);
  end

  always_comb begin
    grp = '0;
    st_next = st;
    if (use2) begin
      st_next = s2.st;
      grp.count = s1.grp.count + s2.grp.count;
      if (s1.grp.count == 2'd0) begin
        grp.beats = s2.grp.beats;
      end else begin
        grp.beats = {s2.grp.beats[1:0], s1.grp.beats[0]};
      end
    end else if (use1) begin
      st_next = s1.st;
      grp = s1.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      st <= '0;
    end else if (advance) begin
      escape_pending <= escape_pending_next;
      st <= st_next;
    end
  end
endmodule

// ----- sv/efd_out_stage.sv -----
// Result register holding up to three beats and sending them one per cycle while frame.ready is high.
module efd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  efd_frame_if.source          frame,
  input  logic                 load,
  input  efd_pkg::beat_group_t grp,
  output logic                 room
);
  import efd_pkg::*;

  logic [1:0]  count;
  beat_t [2:0] beats;

  assign frame.valid          = (count != 2'd0);
  assign frame.frame_byte     = beats[0].data;
  assign frame.first_of_frame = beats[0].first;
  assign frame.last_of_frame  = beats[0].last;
  assign room = (count == 2'd0) || (count == 2'd1 && frame.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= grp.count;
    end else if (frame.valid && frame.ready) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beats <= grp.beats;
    end else if (frame.valid && frame.ready) begin
      beats <= {beat_t'('0), beats[2:1]};
    end
  end
endmodule

// ----- sv/escaped_frame_deframer.sv -----
// Top level of the escaped byte deframer.
//
//   channel | modport | payload                                    | role
//   raw     | sink    | raw_byte                                   | escaped link bytes
//   frame   | source  | frame_byte, first_of_frame, last_of_frame  | framed bytes out
//
// One raw byte enters per cycle while the result register has room; it makes 0 to 3 output
// beats, sent one per cycle while frame.ready is high. A raw beat passes the input register, then the result register.
// A raw byte is processed once the result register is empty or sends its last beat.
// Reset is synchronous and clears escape, hunt window, frame count and both valids.
`include "escaped_frame_deframer_macros.svh"

module escaped_frame_deframer #(
  parameter int unsigned FRAME_OVERHEAD = efd_pkg::FRAME_OVERHEAD_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  efd_raw_if.sink     raw,
  efd_frame_if.source frame
);
  import efd_pkg::*;

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        room;
  logic        advance;
  beat_group_t grp;

  assign advance = item_valid && room;

  efd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  efd_engine #(
    .FRAME_OVERHEAD (FRAME_OVERHEAD)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item_byte (item_byte),
    .grp       (grp)
  );

  efd_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .load  (advance),
    .grp   (grp),
    .room  (room)
  );

  `EFD_ASSERT_NEXT(a_load_shows, clk, rst, advance && grp.count != 2'd0, frame.valid)
  `EFD_ASSERT_NOW(a_first_is_lead, clk, rst, frame.valid && frame.first_of_frame,
                  frame.frame_byte == LEAD_BYTE)
  `EFD_ASSERT_NOW(a_first_not_last, clk, rst, frame.valid && frame.first_of_frame,
                  !frame.last_of_frame)
endmodule

// ----- bench/escaped_frame_deframer_tb.sv -----
// Self-checking bench for the deframer: escaped link bytes in, predicted frame beats checked out.
module escaped_frame_deframer_tb;

  localparam int unsigned OVERHEAD = efd_pkg::FRAME_OVERHEAD_DEFAULT;
  localparam int unsigned LINK_TARGET = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  efd_raw_if raw ();
  efd_frame_if frame ();

  escaped_frame_deframer #(
    .FRAME_OVERHEAD(OVERHEAD)
  ) dut (
    .clk(clk),
    .rst(rst),
    .raw(raw.sink),
    .frame(frame.source)
  );

  always #5 clk = ~clk;

  logic [7:0] link_bytes_q[$];
  efd_pkg::beat_t frame_beats_q[$];

  logic       esc_held;
  logic [7:0] hunt_old;
  logic [7:0] hunt_new;
  logic [1:0] hunt_fill;
  logic       framing;
  logic [6:0] bytes_left;

  int unsigned fed_count;
  int unsigned beat_count;
  int unsigned frame_count;
  int unsigned mismatch_count;
  logic        raw_took;
  logic        hold_sink;
  int unsigned hold_count;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 30) begin
      $display("MISMATCH @%0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic void add_link(input logic [7:0] b);
    link_bytes_q = {link_bytes_q, b};
  endfunction

  function automatic void expect_beat(input logic [7:0] data, input logic first,
                                      input logic last);
    efd_pkg::beat_t bt;
    bt.data = data;
    bt.first = first;
    bt.last = last;
    frame_beats_q = {frame_beats_q, bt};
  endfunction

  // Framing hunt on one unescaped byte.
  function automatic void hunt_byte(input logic [7:0] b);
    int unsigned span;
    if (framing) begin
      bytes_left = (bytes_left == 7'd0) ? 7'd0 : bytes_left - 7'd1;
      expect_beat(b, 1'b0, bytes_left == 7'd0);
      if (bytes_left == 7'd0) begin
        framing = 1'b0;
        hunt_fill = 2'd0;
        hunt_old = 8'd0;
        hunt_new = 8'd0;
      end
    end else if (hunt_fill == 2'd2 && hunt_old == efd_pkg::LEAD_BYTE && hunt_new == 8'd0 &&
                 b >= 8'd1 && b <= efd_pkg::LEN_MAX) begin
      span = int'(b) + OVERHEAD - 3;
      expect_beat(efd_pkg::LEAD_BYTE, 1'b1, 1'b0);
      expect_beat(8'd0, 1'b0, 1'b0);
      expect_beat(b, 1'b0, span == 0);
      hunt_fill = 2'd0;
      hunt_old = 8'd0;
      hunt_new = 8'd0;
      framing = (span != 0);
      bytes_left = span[6:0];
    end else begin
      hunt_old = hunt_new;
      hunt_new = b;
      if (hunt_fill < 2'd2) begin
        hunt_fill = hunt_fill + 2'd1;
      end
    end
  endfunction

  // Unescape one link byte, then hunt on what it yields.
  function automatic void take_link_byte(input logic [7:0] r);
    if (esc_held) begin
      esc_held = 1'b0;
      if (r == efd_pkg::ESC_BYTE) begin
        hunt_byte(efd_pkg::LEAD_BYTE);
      end else if (r == efd_pkg::ESC_SELF) begin
        hunt_byte(efd_pkg::ESC_BYTE);
      end else begin
        hunt_byte(efd_pkg::ESC_BYTE);
        hunt_byte(r);
      end
    end else if (r == efd_pkg::ESC_BYTE) begin
      esc_held = 1'b1;
    end else begin
      hunt_byte(r);
    end
  endfunction

  function automatic void queue_escaped(input logic [7:0] b);
    if (b == efd_pkg::ESC_BYTE) begin
      add_link(efd_pkg::ESC_BYTE);
      add_link(efd_pkg::ESC_SELF);
    end else if (b == efd_pkg::LEAD_BYTE && $urandom_range(0, 1) == 0) begin
      add_link(efd_pkg::ESC_BYTE);
      add_link(efd_pkg::ESC_BYTE);
    end else begin
      add_link(b);
    end
  endfunction

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 11))
      0: return efd_pkg::LEAD_BYTE;
      1: return efd_pkg::ESC_BYTE;
      2: return efd_pkg::ESC_SELF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_frame(input int unsigned len, input int unsigned body);
    queue_escaped(efd_pkg::LEAD_BYTE);
    queue_escaped(8'd0);
    queue_escaped(8'(len));
    for (int unsigned i = 0; i < body; i++) begin
      queue_escaped(pick_payload());
    end
  endfunction

  // Predict on accepted raw beats, check accepted frame beats.
  always @(posedge clk) begin
    efd_pkg::beat_t want;
    raw_took <= !rst && raw.valid && raw.ready;
    if (rst) begin
      esc_held = 1'b0;
      hunt_old = 8'd0;
      hunt_new = 8'd0;
      hunt_fill = 2'd0;
      framing = 1'b0;
      bytes_left = 7'd0;
    end else begin
      if (frame.valid && frame.ready) begin
        beat_count++;
        if (frame.last_of_frame) begin
          frame_count++;
        end
        if (frame_beats_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data %02h first %0b last %0b",
                                    frame.frame_byte, frame.first_of_frame,
                                    frame.last_of_frame));
        end else begin
          want = frame_beats_q.pop_front();
          if (frame.frame_byte !== want.data || frame.first_of_frame !== want.first ||
              frame.last_of_frame !== want.last) begin
            report_mismatch($sformatf("beat %0d got %02h/%0b/%0b want %02h/%0b/%0b",
                                      beat_count, frame.frame_byte, frame.first_of_frame,
                                      frame.last_of_frame, want.data, want.first,
                                      want.last));
          end
        end
      end
      if (raw.valid && raw.ready) begin
        fed_count++;
        take_link_byte(raw.raw_byte);
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    int unsigned gap_left;
    int unsigned burst_left;
    if (rst) begin
      raw.valid <= 1'b0;
    end else if (!raw.valid || raw_took) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        raw.valid <= 1'b0;
      end else if (link_bytes_q.size() != 0) begin
        raw.valid <= 1'b1;
        raw.raw_byte <= link_bytes_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        raw.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern whose mode is redrawn periodically from four choices.
  always @(negedge clk) begin
    int unsigned phase;
    int unsigned mode;
    logic go;
    phase++;
    if (phase % 64 == 0) begin
      mode = $urandom_range(0, 3);
    end
    case (mode)
      0: go = 1'b1;
      1: go = ($urandom_range(0, 1) == 1);
      2: go = (phase % 4 != 0);
      default: go = ($urandom_range(0, 3) == 0);
    endcase
    frame.ready <= go && !hold_sink && !rst;
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    hold_sink = 1'b0;
    hold_count = 0;
    while (fed_count < 120) begin
      @(posedge clk);
    end
    hold_sink = 1'b1;
    repeat (HOLD_OFF_CYCLES) begin
      @(posedge clk);
      hold_count++;
    end
    hold_sink = 1'b0;
  end

  initial begin
    #2000000;
    $display("escaped_frame_deframer verification failed");
    $finish;
  end

  initial begin
    int unsigned len;
    logic big_done;
    raw.valid = 1'b0;
    raw.raw_byte = 8'd0;
    frame.ready = 1'b0;
    fed_count = 0;
    beat_count = 0;
    frame_count = 0;
    mismatch_count = 0;
    big_done = 1'b0;

    // escaped lead byte, shortest length, escaped escape byte as payload
    link_bytes_q = {8'h56, 8'h56, 8'h00, 8'h01, 8'h56, 8'h57};
    // length zero and length above the limit: no header
    add_link(8'h55); add_link(8'h00); add_link(8'h00);
    add_link(8'h55); add_link(8'h00); add_link(8'hFF);
    // escape with other byte inside a frame
    add_link(8'h55); add_link(8'h00); add_link(8'h02);
    add_link(8'h56); add_link(8'h41);
    // escape held across a frame end, its partner starts the next header
    add_link(8'h55); add_link(8'h00); add_link(8'h01);
    add_link(8'h56); add_link(8'h55); add_link(8'h00);
    add_link(8'h03); add_link(8'h00); add_link(8'hFF);
    add_link(8'h80);

    while (link_bytes_q.size() < LINK_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 6)) begin
            add_link(($urandom_range(0, 4) == 0) ? efd_pkg::ESC_BYTE :
                     8'($urandom_range(0, 255)));
          end
        end
        2: begin
          queue_escaped(efd_pkg::LEAD_BYTE);
          queue_escaped(8'd0);
          queue_escaped(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(85, 255)));
        end
        3: begin
          len = $urandom_range(2, 10);
          queue_frame(len, $urandom_range(0, len - 1));
        end
        default: begin
          if (!big_done && link_bytes_q.size() > 150) begin
            len = efd_pkg::LEN_MAX;
            big_done = 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(13, 40);
          end else begin
            len = $urandom_range(1, 12);
          end
          queue_frame(len, len + OVERHEAD - 3);
        end
      endcase
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (link_bytes_q.size() != 0 || raw.valid) begin
      @(posedge clk);
    end
    while (frame_beats_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Fed %0d link bytes; checked %0d frame beats over %0d frames.",
             fed_count, beat_count, frame_count);
    $display("Receiver held off %0d cycles once; %0d mismatches.", hold_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("escaped_frame_deframer verification clean");
    end else begin
      $display("escaped_frame_deframer verification failed");
    end
    $finish;
  end

endmodule
